FILE: rtl/lru_byte_budget_cache_defines.svh
// Assertion macros for the cache RTL, used by the lbc_dp datapath.
`ifndef LRU_BYTE_BUDGET_CACHE_DEFINES_SVH
`define LRU_BYTE_BUDGET_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lbc_pkg.sv
// ---------------------------------------------------------------------------
// lbc_pkg
// Types and codes shared by the LRU byte-budget cache modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

  typedef struct packed {
    logic        cmd;
    logic [31:0] entry_key;
    logic [31:0] entry_bytes;
    logic        gen_failed;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] resource_id;
    logic [4:0]  evicted_count;
    logic [4:0]  item_count;
    logic [31:0] byte_count;
  } out_t;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_GEN_FAIL  = 3'd2;
  localparam logic [2:0] ST_OVER      = 3'd3;
  localparam logic [2:0] ST_BLOCKED   = 3'd4;
  localparam logic [2:0] ST_RELEASED  = 3'd5;
  localparam logic [2:0] ST_REL_UNK   = 3'd6;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic CFG_ITEM_LIMIT  = 1'b0;
  localparam logic CFG_BYTE_BUDGET = 1'b1;

  localparam logic [4:0]  LIMIT_RESET  = 5'd16;
  localparam logic [31:0] BUDGET_RESET = 32'd67108864;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_EVCHK, S_VSCAN, S_VDEC, S_INSERT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOOKUP, OP_RELEASE, OP_HIT, OP_SETST,
    OP_VSCAN, OP_EVICT, OP_INSERT, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] st;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_release;
    logic hit;
    logic rel_ok;
    logic failed;
    logic refuse;
    logic need_evict;
    logic vic_found;
    logic free_found;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lru_byte_budget_cache.sv
// ---------------------------------------------------------------------------
// lru_byte_budget_cache
// Keyed LRU cache of sized entries with item limit, byte budget and leases.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : request channel (valid/stall). cmd 0 acquires entry_key, cmd 1
//           releases one lease on it. entry_bytes/gen_failed matter on a miss.
//   out_* : one result per request (valid/stall): status, resource_id,
//           evicted_count, item_count, byte_count.
//   cfg_* : register writes (index 0 item_limit, 1 byte_budget), always ready;
//           write only while no request is in flight.
// Timing: every request runs a lookup scan of the entry RAM, one entry per
//   cycle; hit, release, failed and refused requests then go straight to the
//   result. A miss adds a full victim scan for each eviction and an insert
//   step, or a last victim scan when no victim is left.
//   One request is handled at a time; the single RAM read port sets the rate.
// Reset: synchronous rst_n clears all valid bits, counters, use clock, id
//   counter (to one) and the configuration registers to their defaults.
// Stall: a result waits in the output register while out_stall is high; the
//   next request is taken once its result has entered the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_byte_budget_cache #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lbc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lbc_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_data
);

  lbc_pkg::ctl_cmd_t ctl_cmd;
  lbc_pkg::dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  lbc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (dp_stat),
    .cmd     (ctl_cmd)
  );

  lbc_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (ctl_cmd),
    .stat     (dp_stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/lbc_ram.sv
// ---------------------------------------------------------------------------
// lbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/lbc_ctrl.sv
// ---------------------------------------------------------------------------
// lbc_ctrl
// Request sequencer: lookup, decision, eviction loop, insert, result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lbc_pkg::dp_stat_t stat,
  output lbc_pkg::ctl_cmd_t      cmd
);

  lbc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbc_pkg::S_IDLE:   if (in_valid) state_nxt = lbc_pkg::S_LOOK;
      lbc_pkg::S_LOOK:   if (stat.scan_done) state_nxt = lbc_pkg::S_DECIDE;
      lbc_pkg::S_DECIDE: begin
        if (stat.is_release || stat.hit || stat.failed || stat.refuse) begin
          state_nxt = lbc_pkg::S_DONE;
        end else begin
          state_nxt = lbc_pkg::S_EVCHK;
        end
      end
      lbc_pkg::S_EVCHK:  state_nxt = stat.need_evict ? lbc_pkg::S_VSCAN : lbc_pkg::S_INSERT;
      lbc_pkg::S_VSCAN:  if (stat.scan_done) state_nxt = lbc_pkg::S_VDEC;
      lbc_pkg::S_VDEC:   state_nxt = stat.vic_found ? lbc_pkg::S_EVCHK : lbc_pkg::S_DONE;
      lbc_pkg::S_INSERT: state_nxt = lbc_pkg::S_DONE;
      lbc_pkg::S_DONE:   if (stat.out_free) state_nxt = lbc_pkg::S_IDLE;
      default:           state_nxt = lbc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = lbc_pkg::OP_NONE;
    cmd.st = lbc_pkg::ST_HIT;
    case (state_r)
      lbc_pkg::S_IDLE: if (in_valid) cmd.op = lbc_pkg::OP_LOOKUP;
      lbc_pkg::S_DECIDE: begin
        if (stat.is_release) begin
          if (stat.rel_ok) begin
            cmd.op = lbc_pkg::OP_RELEASE;
          end else begin
            cmd.op = lbc_pkg::OP_SETST;
            cmd.st = lbc_pkg::ST_REL_UNK;
          end
        end else if (stat.hit) begin
          cmd.op = lbc_pkg::OP_HIT;
        end else if (stat.failed) begin
          cmd.op = lbc_pkg::OP_SETST;
          cmd.st = lbc_pkg::ST_GEN_FAIL;
        end else if (stat.refuse) begin
          cmd.op = lbc_pkg::OP_SETST;
          cmd.st = lbc_pkg::ST_OVER;
        end
      end
      lbc_pkg::S_EVCHK: if (stat.need_evict) cmd.op = lbc_pkg::OP_VSCAN;
      lbc_pkg::S_VDEC: begin
        if (stat.vic_found) begin
          cmd.op = lbc_pkg::OP_EVICT;
        end else begin
          cmd.op = lbc_pkg::OP_SETST;
          cmd.st = lbc_pkg::ST_BLOCKED;
        end
      end
      lbc_pkg::S_INSERT: begin
        if (stat.free_found) begin
          cmd.op = lbc_pkg::OP_INSERT;
        end else begin
          cmd.op = lbc_pkg::OP_SETST;
          cmd.st = lbc_pkg::ST_BLOCKED;
        end
      end
      lbc_pkg::S_DONE: if (stat.out_free) cmd.op = lbc_pkg::OP_OUT;
      default: cmd.op = lbc_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (state_r != lbc_pkg::S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/lbc_dp.sv
// ---------------------------------------------------------------------------
// lbc_dp
// Cache datapath: entry RAM, valid bits, scan pipeline, counters, result reg.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lru_byte_budget_cache_defines.svh"

module lbc_dp #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lbc_pkg::in_t      in_data,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire lbc_pkg::ctl_cmd_t cmd,
  output lbc_pkg::dp_stat_t      stat,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lbc_pkg::out_t          out_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  // entry word: key | bytes | stamp | leases | id
  localparam int ID_LSB = 0;
  localparam int LS_LSB = 32;
  localparam int SM_LSB = 48;
  localparam int BY_LSB = 80;
  localparam int KY_LSB = 112;
  localparam int WW     = KY_LSB + KW;

  // configuration
  logic [4:0]  limit_r;
  logic [31:0] budget_r;

  // bookkeeping
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] use_r, use_nxt;
  logic [31:0] next_id_r, next_id_nxt;

  // per request
  lbc_pkg::in_t req_r, req_nxt;
  logic [2:0]   status_r, status_nxt;
  logic [31:0]  rid_r, rid_nxt;
  logic [CW-1:0] evicted_r, evicted_nxt;

  // scan pipeline
  logic          scan_act_r, scan_act_nxt;
  logic          vmode_r, vmode_nxt;
  logic [IW-1:0] addr_r, addr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;

  // scan results
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [WW-1:0] hit_word_r, hit_word_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic          vic_found_r, vic_found_nxt;
  logic [IW-1:0] vic_idx_r, vic_idx_nxt;
  logic [31:0]   vic_stamp_r, vic_stamp_nxt;
  logic [31:0]   vic_bytes_r, vic_bytes_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  lbc_pkg::out_t out_r, out_nxt;

  // RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] rd_word;

  logic [LW-1:0] lim_raw, lim, cnt_ext, ev_ext;
  logic [15:0]   hit_leases;
  logic [32:0]   bytes_sum;
  logic          rd_valid;

  lbc_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(rd_word)
  );

  always_comb begin
    lim_raw    = LW'(limit_r);
    lim        = (lim_raw > LW'(ENTRIES)) ? LW'(ENTRIES) : lim_raw;
    cnt_ext    = LW'(cnt_r);
    ev_ext     = LW'(evicted_r);
    hit_leases = hit_word_r[LS_LSB +: 16];
    bytes_sum  = {1'b0, total_r} + {1'b0, req_r.entry_bytes};
    rd_valid   = valid_r[rd_idx_r];
  end

  always_comb begin
    stat.scan_done  = rd_vld_r && rd_last_r;
    stat.is_release = (req_r.cmd == lbc_pkg::CMD_RELEASE);
    stat.hit        = hit_r;
    stat.rel_ok     = hit_r && (hit_leases != 16'd0);
    stat.failed     = req_r.gen_failed;
    stat.refuse     = (limit_r == 5'd0) || (req_r.entry_bytes > budget_r);
    stat.need_evict = (cnt_ext >= lim) || (bytes_sum > {1'b0, budget_r});
    stat.vic_found  = vic_found_r;
    stat.free_found = free_found_r;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    use_nxt        = use_r;
    next_id_nxt    = next_id_r;
    req_nxt        = req_r;
    status_nxt     = status_r;
    rid_nxt        = rid_r;
    evicted_nxt    = evicted_r;
    scan_act_nxt   = scan_act_r;
    vmode_nxt      = vmode_r;
    addr_nxt       = addr_r;
    rd_vld_nxt     = 1'b0;
    rd_last_nxt    = 1'b0;
    rd_idx_nxt     = addr_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_word_nxt   = hit_word_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_stamp_nxt  = vic_stamp_r;
    vic_bytes_nxt  = vic_bytes_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;
    ram_wdata      = hit_word_r;

    // issue one read per cycle
    if (scan_act_r) begin
      rd_vld_nxt  = 1'b1;
      rd_last_nxt = (addr_r == IW'(ENTRIES - 1));
      if (addr_r == IW'(ENTRIES - 1)) begin
        scan_act_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + 1'b1;
      end
    end

    // compare the returned entry
    if (rd_vld_r) begin
      if (!vmode_r) begin
        if (rd_valid && !hit_r &&
            rd_word[KY_LSB +: KW] == req_r.entry_key[KW-1:0]) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = rd_idx_r;
          hit_word_nxt = rd_word;
        end
        if (!rd_valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_nxt       = rd_idx_r;
        end
      end else if (rd_valid && rd_word[LS_LSB +: 16] == 16'd0 &&
                   (!vic_found_r || rd_word[SM_LSB +: 32] < vic_stamp_r)) begin
        vic_found_nxt = 1'b1;
        vic_idx_nxt   = rd_idx_r;
        vic_stamp_nxt = rd_word[SM_LSB +: 32];
        vic_bytes_nxt = rd_word[BY_LSB +: 32];
      end
    end

    case (cmd.op)
      lbc_pkg::OP_LOOKUP: begin
        req_nxt        = in_data;
        status_nxt     = lbc_pkg::ST_INSERTED;
        rid_nxt        = 32'd0;
        evicted_nxt    = '0;
        hit_nxt        = 1'b0;
        free_found_nxt = 1'b0;
        vmode_nxt      = 1'b0;
        scan_act_nxt   = 1'b1;
        addr_nxt       = '0;
      end
      lbc_pkg::OP_VSCAN: begin
        vic_found_nxt = 1'b0;
        vmode_nxt     = 1'b1;
        scan_act_nxt  = 1'b1;
        addr_nxt      = '0;
      end
      lbc_pkg::OP_RELEASE: begin
        ram_we                      = 1'b1;
        ram_wdata[LS_LSB +: 16]     = hit_leases - 16'd1;
        status_nxt                  = lbc_pkg::ST_RELEASED;
      end
      lbc_pkg::OP_HIT: begin
        ram_we                  = 1'b1;
        ram_wdata[SM_LSB +: 32] = use_r + 32'd1;
        ram_wdata[LS_LSB +: 16] = (hit_leases == 16'hFFFF) ? hit_leases
                                                            : hit_leases + 16'd1;
        use_nxt                 = use_r + 32'd1;
        rid_nxt                 = hit_word_r[ID_LSB +: 32];
        status_nxt              = lbc_pkg::ST_HIT;
      end
      lbc_pkg::OP_SETST: begin
        status_nxt = cmd.st;
      end
      lbc_pkg::OP_EVICT: begin
        valid_nxt[vic_idx_r] = 1'b0;
        cnt_nxt              = cnt_r - 1'b1;
        total_nxt            = total_r - vic_bytes_r;
        evicted_nxt          = evicted_r + 1'b1;
        if (!free_found_r || vic_idx_r < free_r) begin
          free_found_nxt = 1'b1;
          free_nxt       = vic_idx_r;
        end
      end
      lbc_pkg::OP_INSERT: begin
        ram_we             = 1'b1;
        ram_waddr          = free_r;
        ram_wdata          = {req_r.entry_key[KW-1:0], req_r.entry_bytes,
                              use_r + 32'd1, 16'd1, next_id_r};
        valid_nxt[free_r]  = 1'b1;
        cnt_nxt            = cnt_r + 1'b1;
        total_nxt          = bytes_sum[31:0];
        use_nxt            = use_r + 32'd1;
        next_id_nxt        = next_id_r + 32'd1;
        rid_nxt            = next_id_r;
        status_nxt         = lbc_pkg::ST_INSERTED;
        free_found_nxt     = 1'b0;
      end
      lbc_pkg::OP_OUT: begin
        out_valid_nxt         = 1'b1;
        out_nxt.status        = status_r;
        out_nxt.resource_id   = rid_r;
        out_nxt.evicted_count = ev_ext[4:0];
        out_nxt.item_count    = cnt_ext[4:0];
        out_nxt.byte_count    = total_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= lbc_pkg::LIMIT_RESET;
      budget_r    <= lbc_pkg::BUDGET_RESET;
      valid_r     <= '0;
      cnt_r       <= '0;
      total_r     <= 32'd0;
      use_r       <= 32'd0;
      next_id_r   <= 32'd1;
      scan_act_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == lbc_pkg::CFG_ITEM_LIMIT) begin
        limit_r <= cfg_data[4:0];
      end
      if (cfg_valid && cfg_index == lbc_pkg::CFG_BYTE_BUDGET) begin
        budget_r <= cfg_data;
      end
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      use_r       <= use_nxt;
      next_id_r   <= next_id_nxt;
      scan_act_r  <= scan_act_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    status_r     <= status_nxt;
    rid_r        <= rid_nxt;
    evicted_r    <= evicted_nxt;
    vmode_r      <= vmode_nxt;
    addr_r       <= addr_nxt;
    rd_last_r    <= rd_last_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_word_r   <= hit_word_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    vic_found_r  <= vic_found_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_stamp_r  <= vic_stamp_nxt;
    vic_bytes_r  <= vic_bytes_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LBC_ASSERT_NOW(a_cnt_matches_valid, 1'b1, cnt_r == CW'($countones(valid_r)), "held count drifted from valid bits")
  `LBC_ASSERT_NOW(a_evict_valid, cmd.op == lbc_pkg::OP_EVICT, valid_r[vic_idx_r], "evicting an empty slot")
  `LBC_ASSERT_NOW(a_insert_free, cmd.op == lbc_pkg::OP_INSERT, !valid_r[free_r], "inserting into a held slot")

endmodule

`default_nettype wire
